>>> rtl/hk_pkg.sv
// ----------------------------------------------------------------------------
// hk_pkg: shared types and constants of the Held-Karp tour solver
// Widths, command and status structs joining controller and datapath.
// ----------------------------------------------------------------------------
package hk_pkg;

	localparam int MAX_VERTICES_DEF = 12;
	localparam int WEIGHT_BITS_DEF  = 16;
	localparam int VTX_BITS         = 4;
	localparam int COST_BITS        = 20;
	localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
	localparam int CNT_BITS         = 4;

	// register indexes
	localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_FILL,   // one (set, t, q) step of the fill
		OP_CLOSE,  // one t step of the closing minimum
		OP_BACK,   // one v step of the backtrack
		OP_INIT    // clear accumulators
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [VTX_BITS-1:0] a;      // t for fill/close, v for back
		logic [VTX_BITS-1:0] q;      // q for fill
		logic [15:0]         set;    // subset for fill
		logic                first;  // first term of a minimum
		logic                last;   // last term: write result
	} hk_cmd_t;

	typedef struct packed {
		logic [VTX_BITS-1:0] pick;
		logic [15:0]         rem;
	} hk_sts_t;

	// saturating add
	function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
			input logic [COST_BITS-1:0] b);
		logic [COST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
	endfunction

endpackage

>>> rtl/hk_if.sv
// ----------------------------------------------------------------------------
// hk_in_if / hk_out_if: valid-ready channels of the solver
// Edge-weight load items in, tour vertices out.
// ----------------------------------------------------------------------------
interface hk_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] from_vertex;
	logic [3:0] to_vertex;
	logic [15:0] weight;
	logic       solve_req;
	modport source (output valid, from_vertex, to_vertex, weight, solve_req, input ready);
	modport sink   (input valid, from_vertex, to_vertex, weight, solve_req, output ready);
endinterface

interface hk_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  tour_vertex;
	logic [19:0] tour_cost;
	logic        last_of_tour;
	modport source (output valid, tour_vertex, tour_cost, last_of_tour, input ready);
	modport sink   (input valid, tour_vertex, tour_cost, last_of_tour, output ready);
endinterface

>>> rtl/held_karp_tour_solver.sv
// A solve takes about m*m*2^(m-2) fill steps (m = vertex_count-1), at most
// one per cycle through the subset-cost memory port, then m closing steps and
// about m*m backtrack steps before the first vertex. Results then leave one
// per cycle while out_ch.ready is high. One solve at a time.
// Reset (arst_n low) clears control state and sets vertex_count to 12.
// ----------------------------------------------------------------------------
// held_karp_tour_solver: exact asymmetric TSP solver by Held-Karp
// APB register port, weight load channel, tour output channel.
// ----------------------------------------------------------------------------
module held_karp_tour_solver #(
	parameter int MAX_VERTICES = hk_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = hk_pkg::WEIGHT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	hk_in_if.sink       in_ch,
	hk_out_if.source    out_ch
);
	localparam int VB = hk_pkg::VTX_BITS;

	logic [3:0] vcount_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= 4'd12;
		else if (psel && penable && pwrite && paddr[1:1] == hk_pkg::REG_VERTEX_COUNT)
			vcount_q <= pwdata[3:0];
	end
	assign prdata = (paddr[1:1] == hk_pkg::REG_VERTEX_COUNT) ? {28'd0, vcount_q} : 32'd0;

	logic [VB-1:0] n_eff;
	always_comb begin
		if (vcount_q < 4'd2) n_eff = 4'd2;
		else if (32'(vcount_q) > MAX_VERTICES) n_eff = VB'(MAX_VERTICES);
		else n_eff = vcount_q;
	end

	logic busy, acc, dw_en;
	assign in_ch.ready = !busy;
	assign acc = in_ch.valid && in_ch.ready;
	assign dw_en = acc && 32'(in_ch.from_vertex) < MAX_VERTICES
		&& 32'(in_ch.to_vertex) < MAX_VERTICES;

	hk_pkg::hk_cmd_t cmd;
	hk_pkg::hk_sts_t sts;
	logic [hk_pkg::COST_BITS-1:0] best_cost;

	hk_datapath #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk, .arst_n, .dw_en,
		.dw_from(in_ch.from_vertex), .dw_to(in_ch.to_vertex),
		.dw_data(WEIGHT_BITS'(in_ch.weight)),
		.start_vtx(n_eff - 1'b1), .cmd, .sts, .best_cost
	);

	hk_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk, .arst_n, .solve_go(acc && in_ch.solve_req), .n_eff,
		.sts, .best_cost, .cmd, .busy, .out_ch
	);
endmodule

>>> rtl/hk_datapath.sv
// ----------------------------------------------------------------------------
// hk_datapath: distance and subset-cost memories with a min/add unit
// Two-stage step: registered memory reads, then saturating add and minimum.
// ----------------------------------------------------------------------------
module hk_datapath #(
	parameter int MAX_VERTICES = hk_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = hk_pkg::WEIGHT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// weight write
	input  logic                          dw_en,
	input  logic [hk_pkg::VTX_BITS-1:0]   dw_from,
	input  logic [hk_pkg::VTX_BITS-1:0]   dw_to,
	input  logic [WEIGHT_BITS-1:0]        dw_data,
	input  logic [hk_pkg::VTX_BITS-1:0]   start_vtx,
	input  hk_pkg::hk_cmd_t               cmd,
	output hk_pkg::hk_sts_t               sts,
	output logic [hk_pkg::COST_BITS-1:0]  best_cost
);
	localparam int M        = MAX_VERTICES - 1;
	localparam int SETS     = 1 << M;
	localparam int DDEPTH   = MAX_VERTICES * MAX_VERTICES;
	localparam int DA_BITS  = $clog2(DDEPTH);
	localparam int TA_BITS  = $clog2(M * SETS);
	localparam int VB       = hk_pkg::VTX_BITS;
	localparam int CB       = hk_pkg::COST_BITS;

	logic [WEIGHT_BITS-1:0] dist_mem [DDEPTH];
	logic [CB-1:0]          tbl_mem  [M * SETS];

	// stage-0 address forming
	logic [M-1:0] set0, rest0, tb0, tread_set0;
	logic [VB-1:0] d_from0, d_to0, t_end0;
	always_comb begin
		set0  = cmd.set[M-1:0];
		tb0   = '0;
		tb0[cmd.a[$clog2(M)-1:0]] = 1'b1;
		rest0 = set0 & ~tb0;
		d_from0 = cmd.q;
		d_to0   = cmd.a;
		t_end0  = cmd.q;
		tread_set0 = rest0;
		unique case (cmd.op)
			hk_pkg::OP_FILL: begin
				if (rest0 == '0) d_from0 = start_vtx;
			end
			hk_pkg::OP_CLOSE: begin
				d_from0 = cmd.a; d_to0 = start_vtx; t_end0 = cmd.a;
				tread_set0 = set0;
			end
			hk_pkg::OP_BACK: begin
				d_from0 = cmd.a; d_to0 = sts.pick; t_end0 = cmd.a;
				tread_set0 = sts.rem[M-1:0];
			end
			default: ;
		endcase
	end

	logic [DA_BITS-1:0] daddr0;
	logic [TA_BITS-1:0] traddr0;
	assign daddr0  = DA_BITS'(32'(d_from0) * MAX_VERTICES + 32'(d_to0));
	assign traddr0 = TA_BITS'(32'(t_end0) * SETS + 32'(tread_set0));

	// subset-cost write from stage 2
	logic               tw_en2;
	logic [TA_BITS-1:0] twaddr2;
	assign tw_en2  = cmd_s1.op == hk_pkg::OP_FILL && cmd_s1.last;
	assign twaddr2 = TA_BITS'(32'(cmd_s1.a) * SETS + 32'(cmd_s1.set[M-1:0]));

	// stage 1: registered reads
	logic [WEIGHT_BITS-1:0] dist_s1;
	logic [CB-1:0]          cell_s1;
	logic [CB-1:0]          bypd_s1;
	hk_pkg::hk_cmd_t        cmd_s1;
	logic                   single_s1;
	logic                   byp_s1;
	logic [CB-1:0]          newmin;
	always_ff @(posedge clk) begin
		if (dw_en)
			dist_mem[DA_BITS'(32'(dw_from) * MAX_VERTICES + 32'(dw_to))] <= dw_data;
		dist_s1 <= dist_mem[daddr0];
		cell_s1 <= tbl_mem[traddr0];
		bypd_s1 <= newmin;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1    <= '0;
			single_s1 <= 1'b0;
			byp_s1    <= 1'b0;
		end else begin
			cmd_s1    <= cmd;
			single_s1 <= (cmd.op == hk_pkg::OP_FILL) && (rest0 == '0);
			// entry read while it is being written: take the new value
			byp_s1    <= tw_en2 && (twaddr2 == traddr0);
		end
	end

	// stage 2: add and minimum
	logic [CB-1:0] sum1, acc_q, cell_v;
	logic          better;
	assign cell_v = byp_s1 ? bypd_s1 : cell_s1;
	assign sum1 = hk_pkg::sat_add(single_s1 ? '0 : cell_v, CB'(dist_s1));
	assign better = cmd_s1.first || (sum1 < acc_q);
	assign newmin = better ? sum1 : acc_q;

	always_ff @(posedge clk) begin
		if (tw_en2)
			tbl_mem[twaddr2] <= newmin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			best_cost <= '0;
		end else begin
			unique case (cmd_s1.op)
				hk_pkg::OP_FILL, hk_pkg::OP_CLOSE, hk_pkg::OP_BACK: begin
					acc_q <= newmin;
					if (cmd_s1.op == hk_pkg::OP_CLOSE && cmd_s1.last) best_cost <= newmin;
				end
				default: ;
			endcase
		end
	end

	// backtrack pick tracked separately: candidate kept until the step ends
	logic [VB-1:0] cand_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (cmd_s1.op == hk_pkg::OP_BACK) begin
			if (better) cand_q <= cmd_s1.a;
		end
	end

	// commit the pick at the end of one backtrack step
	logic [VB-1:0] fin_pick;
	assign fin_pick = (cmd_s1.op == hk_pkg::OP_BACK && better) ? cmd_s1.a : cand_q;
	logic commit;
	assign commit = cmd_s1.op == hk_pkg::OP_BACK && cmd_s1.last;
	logic [M-1:0] fmask;
	always_comb begin
		fmask = '0;
		fmask[fin_pick[$clog2(M)-1:0]] = 1'b1;
	end

	logic [VB-1:0] pickc_q;
	logic [15:0]   remc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pickc_q <= '0;
			remc_q  <= '0;
		end else if (cmd_s1.op == hk_pkg::OP_INIT) begin
			pickc_q <= start_vtx;
			remc_q  <= cmd_s1.set;
		end else if (commit) begin
			pickc_q <= fin_pick;
			remc_q  <= remc_q & ~16'(fmask);
		end
	end

	assign sts.pick = pickc_q;
	assign sts.rem  = remc_q;
endmodule

>>> rtl/hk_ctrl.sv
// ----------------------------------------------------------------------------
// hk_ctrl: sequencer of the Held-Karp fill, closing minimum and backtrack
// Issues at most one datapath step per cycle and hands tour vertices to the output.
// ----------------------------------------------------------------------------
module hk_ctrl #(
	parameter int MAX_VERTICES = hk_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          solve_go,
	input  logic [hk_pkg::VTX_BITS-1:0]   n_eff,
	input  hk_pkg::hk_sts_t               sts,
	input  logic [hk_pkg::COST_BITS-1:0]  best_cost,
	output hk_pkg::hk_cmd_t               cmd,
	output logic                          busy,
	hk_out_if.source                      out_ch
);
	localparam int VB = hk_pkg::VTX_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_FILL, S_CLOSE, S_DRAIN, S_BINIT, S_BACK, S_BWAIT, S_EMIT
	} state_t;

	state_t        state_q;
	logic [15:0]   set_q;
	logic [VB-1:0] t_q, q_q, m_q, i_q;
	logic [VB-1:0] tour_q [MAX_VERTICES];
	logic [1:0]    wait_q;

	logic [15:0] full;
	assign full = 16'((17'd1 << m_q) - 17'd1);

	logic [15:0] restset;
	assign restset = set_q & ~(16'd1 << t_q);

	// first q in the rest set
	logic [VB-1:0] q_first;
	always_comb begin
		q_first = '0;
		for (int k = MAX_VERTICES - 2; k >= 0; k--) begin
			if (restset[k]) q_first = VB'(k);
		end
	end
	logic [VB-1:0] qcur;
	assign qcur = (q_q == '1) ? q_first : q_q;

	// next q in the rest set after the current one
	logic [VB-1:0] q_next;
	always_comb begin
		q_next = '0;
		for (int k = MAX_VERTICES - 2; k >= 0; k--) begin
			if (restset[k] && VB'(k) > qcur) q_next = VB'(k);
		end
	end

	// command
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_FILL: begin
				cmd.op = set_q[t_q] ? hk_pkg::OP_FILL : hk_pkg::OP_NONE;
				cmd.a = t_q; cmd.set = set_q;
				cmd.first = (q_q == '1);
				cmd.q = qcur;
				cmd.last = (restset == '0) || !(|(restset & ~((16'd2 << cmd.q) - 16'd1)));
			end
			S_CLOSE: begin
				cmd.op = hk_pkg::OP_CLOSE; cmd.a = t_q; cmd.set = full;
				cmd.first = (t_q == '0); cmd.last = (t_q == m_q - 1'b1);
			end
			S_BINIT: begin
				cmd.op = hk_pkg::OP_INIT; cmd.set = full;
			end
			S_BACK: begin
				cmd.op = sts.rem[t_q] ? hk_pkg::OP_BACK : hk_pkg::OP_NONE;
				cmd.a = t_q;
				cmd.first = !(|(sts.rem & ((16'd1 << t_q) - 16'd1)));
				cmd.last = !(|(sts.rem & ~((16'd2 << t_q) - 16'd1)));
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign out_ch.tour_cost = best_cost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			set_q <= '0; t_q <= '0; q_q <= '1; m_q <= '0; i_q <= '0; wait_q <= '0;
			out_ch.valid <= 1'b0;
			out_ch.tour_vertex <= '0;
			out_ch.last_of_tour <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (solve_go) begin
					m_q <= n_eff - 1'b1; set_q <= 16'd1; t_q <= '0; q_q <= '1;
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (cmd.op == hk_pkg::OP_FILL && !cmd.last) begin
						q_q <= q_next;
					end else begin
						q_q <= '1;
						// a write of this set lands after the stage-1 register, at the stage-2
						// table write; the datapath forwards it when the next set reads it at once
						if (t_q == m_q - 1'b1) begin
							t_q <= '0;
							if (set_q == full) begin
								state_q <= S_DRAIN; wait_q <= 2'd2;
							end else set_q <= set_q + 16'd1;
						end else t_q <= t_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (wait_q == 2'd0) begin
						state_q <= S_CLOSE; t_q <= '0;
					end else wait_q <= wait_q - 2'd1;
				end
				S_CLOSE: begin
					if (cmd.last) state_q <= S_BINIT;
					else t_q <= t_q + 1'b1;
					i_q <= m_q;
				end
				S_BINIT: begin
					tour_q[m_q] <= n_eff - 1'b1;
					state_q <= S_BWAIT; wait_q <= 2'd2; t_q <= '0;
				end
				S_BWAIT: begin
					if (wait_q == 2'd0) begin
						if (i_q == '0) begin
							state_q <= S_EMIT; i_q <= '0;
							out_ch.valid <= 1'b1;
							// front vertex is the pick just committed
							out_ch.tour_vertex <= sts.pick;
							out_ch.last_of_tour <= 1'b0;
						end else begin
							state_q <= S_BACK; t_q <= '0;
						end
					end else wait_q <= wait_q - 2'd1;
				end
				S_BACK: begin
					if (cmd.op == hk_pkg::OP_BACK && cmd.last) begin
						state_q <= S_BWAIT; wait_q <= 2'd1;
						i_q <= i_q - 1'b1;
					end else t_q <= t_q + 1'b1;
				end
				S_EMIT: if (out_ch.ready) begin
					if (out_ch.last_of_tour) begin
						out_ch.valid <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						out_ch.tour_vertex <= tour_q[i_q + 1'b1];
						out_ch.last_of_tour <= (i_q + 1'b1 == m_q);
						i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// record committed pick once it settles
			if (state_q == S_BWAIT && wait_q == 2'd0 && i_q != m_q)
				tour_q[i_q] <= sts.pick;
		end
	end
endmodule

>>> rtl/hk_checker.sv
// ----------------------------------------------------------------------------
// hk_checker: port-level checks of the tour solver
// Output handshake and tour framing properties.
// ----------------------------------------------------------------------------
module hk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  tour_vertex,
	input logic [19:0] tour_cost,
	input logic        last_of_tour
);
	// held result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tour_vertex))
		else $error("output item dropped");
	// no input taken while a tour is emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during emit");
	// cost constant within a tour
	a_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_tour |=> $stable(tour_cost))
		else $error("cost changed within tour");
	// an accepted item never yields a result in the next cycle
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result right after an input item");
endmodule

bind held_karp_tour_solver hk_checker u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.tour_vertex(out_ch.tour_vertex), .tour_cost(out_ch.tour_cost),
	.last_of_tour(out_ch.last_of_tour)
);
